// File: rtl/mcg_pkg.sv
// Package for the month calendar grid block: widths, constants, month tables
// and the start word passed from the start pipeline to the cell generator.
// No dependencies.
package mcg_pkg;

  localparam int GRID_CELLS = 42;
  localparam int CELL_W     = $clog2(GRID_CELLS);
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 12;
  localparam int DAY_W      = 5;
  localparam int COL_W      = 3;
  localparam int SUM_W      = 13;
  localparam int Q100_W     = 6;
  localparam int PROD_W     = 25;

  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int CENTURY      = 100;
  localparam int YEAR_SHIFT   = 400;
  localparam int LEAP_CENTURY = 4;

  localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

  localparam logic [COL_W-1:0] SAT_COL  = COL_W'(5);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(6);
  localparam logic [COL_W-1:0] MONDAY   = COL_W'(1);
  localparam logic [COL_W-1:0] SUNDAY   = COL_W'(7);

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] target_month;
    logic [DAY_W-1:0]   target_today;
    logic               leap;
  } grid_start_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                  len = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
      default:               len = DAY_W'(31);
    endcase
    return len;
  endfunction

  // floor(31 * mm / 12) with March as month one of the shifted year
  function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] m);
    logic [4:0] t;
    case (m)
      4'd1:    t = 5'd28;
      4'd2:    t = 5'd31;
      4'd3:    t = 5'd2;
      4'd4:    t = 5'd5;
      4'd5:    t = 5'd7;
      4'd6:    t = 5'd10;
      4'd7:    t = 5'd12;
      4'd8:    t = 5'd15;
      4'd9:    t = 5'd18;
      4'd10:   t = 5'd20;
      4'd11:   t = 5'd23;
      default: t = 5'd25;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/mcg_req_if.sv
// Request channel of the month calendar grid block: one word asks for a page.
// Depends on mcg_pkg.
interface mcg_req_if import mcg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MONTH_W-1:0] shown_month;
  logic [YEAR_W-1:0]  shown_year;
  logic [DAY_W-1:0]   today_day;

  modport source (output valid, shown_month, shown_year, today_day, input ready);
  modport sink   (input valid, shown_month, shown_year, today_day, output ready);
endinterface

// File: rtl/mcg_cell_if.sv
// Cell channel of the month calendar grid block: one word per grid cell.
// Depends on mcg_pkg.
interface mcg_cell_if import mcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_index;
  logic [DAY_W-1:0]  day_number;
  logic              in_shown_month;
  logic              weekend;
  logic              is_today;
  logic              last;

  modport source (output valid, cell_index, day_number, in_shown_month, weekend,
                  is_today, last, input ready);
  modport sink   (input valid, cell_index, day_number, in_shown_month, weekend,
                  is_today, last, output ready);
endinterface

// File: rtl/month_calendar_grid_core.sv
// Top level of the month calendar grid block: start pipeline and cell generator.
// Depends on mcg_pkg, mcg_req_if, mcg_cell_if, mcg_start, mcg_cells.
//
//   channel  dir  handshake          word
//   req      in   valid/ready        shown_month, shown_year, today_day
//   grid     out  valid/ready        cell_index, day_number, in_shown_month,
//                                    weekend, is_today, last
//
// Each request yields 42 cell words, one per cycle from the cell generator while
// grid does not stall. After a request is taken into start stage one, the first
// cell word passes start stages two and three, the cursor load and the output
// register before it is valid.
// The start stages take the next request while the current grid is emitted.
// Reset clears all valid and busy flags. A stall on grid holds the word and
// freezes the cursors; req.ready drops once the start stages are full.
module month_calendar_grid_core import mcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcg_req_if.sink    req,
  mcg_cell_if.source grid
);

  logic        start_valid;
  logic        start_ready;
  grid_start_t start_word;

  mcg_start u_start (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req),
    .start_valid_o (start_valid),
    .start_ready_i (start_ready),
    .start_o       (start_word)
  );

  mcg_cells u_cells (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_valid_i (start_valid),
    .start_ready_o (start_ready),
    .start_i       (start_word),
    .grid          (grid)
  );

endmodule

// File: rtl/mcg_start.sv
// Start pipeline: three register stages turn a request into the first cell's
// day and month, the leap flag and the targets. Depends on mcg_pkg, mcg_req_if.
module mcg_start import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mcg_req_if.sink     req,
  output logic        start_valid_o,
  input  logic        start_ready_i,
  output grid_start_t start_o
);

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_ready, s2_ready, s3_ready;

  logic [MONTH_W-1:0] s1_mon_q;
  logic [YEAR_W-1:0]  s1_year_q;
  logic [DAY_W-1:0]   s1_today_q;

  logic [MONTH_W-1:0] s2_mon_q;
  logic               s2_a_q;
  logic [YEAR_W-1:0]  s2_year_q;
  logic [Q100_W-1:0]  s2_q100_q;
  logic [DAY_W-1:0]   s2_today_q;

  logic [SUM_W-1:0]   s3_sum_q;
  logic [MONTH_W-1:0] s3_mon_q;
  logic               s3_leap_q;
  logic [DAY_W-1:0]   s3_today_q;

  // stage 1: clamp month, divide year by one hundred
  logic [MONTH_W-1:0] mon_c;
  logic [PROD_W-1:0]  prod;
  logic [Q100_W-1:0]  q100;

  always_comb begin
    if (s1_mon_q < JAN) begin
      mon_c = JAN;
    end else if (s1_mon_q > DEC) begin
      mon_c = DEC;
    end else begin
      mon_c = s1_mon_q;
    end
    prod = PROD_W'(s1_year_q) * PROD_W'(DIV100_MUL);
    q100 = prod[DIV100_SHIFT +: Q100_W];
  end

  // stage 2: leap year and day count
  logic [YEAR_W-1:0] hund;
  logic              cent_zero;
  logic              leap;
  logic [Q100_W-1:0] yq;
  logic [SUM_W-1:0]  yy;
  logic [SUM_W-1:0]  sum;

  always_comb begin
    hund      = YEAR_W'(s2_q100_q) * YEAR_W'(CENTURY);
    cent_zero = (hund == s2_year_q);
    leap      = ((s2_year_q[1:0] == 2'd0) && !cent_zero) ||
                (cent_zero && (s2_q100_q[1:0] == 2'd0));
    yq        = s2_q100_q + Q100_W'(LEAP_CENTURY) - Q100_W'(s2_a_q & cent_zero);
    yy        = SUM_W'(s2_year_q) + SUM_W'(YEAR_SHIFT) - SUM_W'(s2_a_q);
    sum       = SUM_W'(1) + yy + (yy >> 2) - SUM_W'(yq) + SUM_W'(yq >> 2) +
                SUM_W'(month_term(s2_mon_q));
  end

  // stage 3: weekday of day one, then the first cell
  logic [4:0]         t1;
  logic [3:0]         t2;
  logic [COL_W-1:0]   rem7;
  logic [COL_W-1:0]   wd;
  logic [MONTH_W-1:0] prev_mon;
  grid_start_t        start_c;

  always_comb begin
    t1 = 5'(s3_sum_q[2:0]) + 5'(s3_sum_q[5:3]) + 5'(s3_sum_q[8:6]) +
         5'(s3_sum_q[11:9]) + 5'(s3_sum_q[12]);
    t2 = 4'(t1[2:0]) + 4'(t1[4:3]);
    rem7 = (t2 >= 4'd7) ? COL_W'(t2 - 4'd7) : t2[2:0];
    wd = (rem7 == '0) ? SUNDAY : rem7;
    prev_mon = (s3_mon_q == JAN) ? DEC : s3_mon_q - MONTH_W'(1);
    start_c.target_month = s3_mon_q;
    start_c.target_today = s3_today_q;
    start_c.leap         = s3_leap_q;
    if (wd == MONDAY) begin
      start_c.month = s3_mon_q;
      start_c.day   = DAY_W'(1);
    end else begin
      start_c.month = prev_mon;
      start_c.day   = month_len(prev_mon, s3_leap_q) - DAY_W'(wd) + DAY_W'(2);
    end
  end

  assign s3_ready  = !s3_v_q || start_ready_i;
  assign s2_ready  = !s2_v_q || s3_ready;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign req.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) s1_v_q <= req.valid;
      if (s2_ready) s2_v_q <= s1_v_q;
      if (s3_ready) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && req.valid) begin
      s1_mon_q   <= req.shown_month;
      s1_year_q  <= req.shown_year;
      s1_today_q <= req.today_day;
    end
    if (s2_ready && s1_v_q) begin
      s2_mon_q   <= mon_c;
      s2_a_q     <= (mon_c <= FEB);
      s2_year_q  <= s1_year_q;
      s2_q100_q  <= q100;
      s2_today_q <= s1_today_q;
    end
    if (s3_ready && s2_v_q) begin
      s3_sum_q   <= sum;
      s3_mon_q   <= s2_mon_q;
      s3_leap_q  <= leap;
      s3_today_q <= s2_today_q;
    end
  end

  assign start_valid_o = s3_v_q;
  assign start_o       = start_c;

endmodule

// File: rtl/mcg_cells.sv
// Cell generator: while grid does not stall, walks the day and month cursors
// one cell per cycle into a registered output word. Depends on mcg_pkg, mcg_cell_if.
module mcg_cells import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_valid_i,
  output logic        start_ready_o,
  input  grid_start_t start_i,
  mcg_cell_if.source  grid
);

  logic               busy_q;
  logic [CELL_W-1:0]  cnt_q;
  logic [COL_W-1:0]   col_q;
  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] mon_q;
  logic [MONTH_W-1:0] tmon_q;
  logic [DAY_W-1:0]   ttoday_q;
  logic               leap_q;

  logic               ov_q;
  logic [CELL_W-1:0]  idx_q;
  logic [DAY_W-1:0]   dnum_q;
  logic               inm_q;
  logic               wkend_q;
  logic               today_q;
  logic               last_q;

  logic out_free, emit, last_cell, load, inm;

  assign out_free      = !ov_q || grid.ready;
  assign emit          = busy_q && out_free;
  assign last_cell     = (cnt_q == CELL_W'(GRID_CELLS - 1));
  assign start_ready_o = !busy_q || (emit && last_cell);
  assign load          = start_valid_i && start_ready_o;
  assign inm           = (mon_q == tmon_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      col_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        col_q  <= '0;
      end else if (emit) begin
        busy_q <= !last_cell;
        cnt_q  <= cnt_q + CELL_W'(1);
        col_q  <= (col_q == LAST_COL) ? '0 : col_q + COL_W'(1);
      end
      if (out_free) ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      day_q    <= start_i.day;
      mon_q    <= start_i.month;
      tmon_q   <= start_i.target_month;
      ttoday_q <= start_i.target_today;
      leap_q   <= start_i.leap;
    end else if (emit) begin
      if (day_q < month_len(mon_q, leap_q)) begin
        day_q <= day_q + DAY_W'(1);
      end else begin
        day_q <= DAY_W'(1);
        mon_q <= (mon_q == DEC) ? JAN : mon_q + MONTH_W'(1);
      end
    end
    if (emit) begin
      idx_q   <= cnt_q;
      dnum_q  <= day_q;
      inm_q   <= inm;
      wkend_q <= (col_q >= SAT_COL);
      today_q <= inm && (day_q == ttoday_q);
      last_q  <= last_cell;
    end
  end

  assign grid.valid          = ov_q;
  assign grid.cell_index     = idx_q;
  assign grid.day_number     = dnum_q;
  assign grid.in_shown_month = inm_q;
  assign grid.weekend        = wkend_q;
  assign grid.is_today       = today_q;
  assign grid.last           = last_q;

endmodule

// File: rtl/mcg_checker.sv
// Port checker for the month calendar grid block, bound to the top level.
// Depends on mcg_pkg and month_calendar_grid_core.
module mcg_checker import mcg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              ready_i,
  input logic [CELL_W-1:0] cell_index_i,
  input logic [DAY_W-1:0]  day_number_i,
  input logic              in_shown_month_i,
  input logic              is_today_i,
  input logic              last_i
);

  logic [CELL_W-1:0] exp_idx_q;
  logic              acc;

  assign acc = valid_i && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (acc) begin
      exp_idx_q <= last_i ? '0 : exp_idx_q + CELL_W'(1);
    end
  end

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> (cell_index_i == exp_idx_q))
    else $error("cell index out of sequence");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (last_i == (cell_index_i == CELL_W'(GRID_CELLS - 1))))
    else $error("last flag on wrong cell");

  a_today_in_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && is_today_i) |-> (in_shown_month_i && (day_number_i != '0)))
    else $error("today flag outside shown month");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !ready_i) |=> (valid_i && $stable(cell_index_i) &&
                               $stable(day_number_i)))
    else $error("stalled word changed");

endmodule

bind month_calendar_grid_core mcg_checker u_mcg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (grid.valid),
  .ready_i          (grid.ready),
  .cell_index_i     (grid.cell_index),
  .day_number_i     (grid.day_number),
  .in_shown_month_i (grid.in_shown_month),
  .is_today_i       (grid.is_today),
  .last_i           (grid.last)
);
